>>> src/ttcq_pkg.sv
// Shared types and character constants for the text tokenizer.
package ttcq_pkg;

	localparam int unsigned DEF_MAX_TOKEN_LEN = 128;
	localparam int unsigned DEF_POSITION_BITS = 16;

	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned PTR_W    = $clog2(QDEPTH);
	localparam int unsigned CNT_W    = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_EOT  = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		MODE_SKIP    = 5'b00001,
		MODE_SLASH   = 5'b00010,
		MODE_COMMENT = 5'b00100,
		MODE_QUOTED  = 5'b01000,
		MODE_WORD    = 5'b10000
	} mode_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           tbyte;
		logic                 quoted;
		logic                 disc;
		logic [OFFSET_W-1:0]  offs;
		logic                 last;
	} res_t;

endpackage

>>> src/text_tokenizer_comments_quotes.sv
// Streaming tokenizer: splits a byte stream into bare words and quoted strings.

// The block takes one text byte per beat on the input channel (a zero byte ends
// the text) and reports tokens on the output channel, one result per beat: each
// token character as it arrives (kind 0), a token-end beat with the start offset
// and the quoted and discarded flags (kind 1), and an end-of-text beat (kind 2).
// Whitespace, control bytes and bytes above 127 are skipped between tokens, and
// a double-slash comment is skipped up to the newline. The flag last marks the
// final result caused by one input byte; some bytes cause none. An accepted
// byte is decoded from the input register in the cycle after acceptance, and its
// results are pushed into a four-entry result queue once all of them fit; the
// queue output drives the result ports. Sustained rate is one byte per cycle as
// long as each byte causes at most one result and the output is not stalled; a
// byte that causes two or three results (a lone slash followed by a word character
// or a delimiter, end of text inside a token) needs an output beat for each, and
// the result queue throttles the input through in_stall until the results drain.
module text_tokenizer_comments_quotes
	import ttcq_pkg::*;
#(
	parameter int unsigned MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
	parameter int unsigned POSITION_BITS = DEF_POSITION_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          text_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic [7:0]          token_byte,
	output logic                quoted,
	output logic                discarded,
	output logic [OFFSET_W-1:0] start_offset,
	output logic                last
);

	localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TOKEN_LEN);
	localparam logic [LEN_W-1:0] LEN_QMAX = LEN_W'(MAX_TOKEN_LEN - 1);
	localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	// Saturating increment of a text offset.
	function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
		logic [POSITION_BITS-1:0] r;
		r = (v == POS_MAX) ? v : v + POSITION_BITS'(1);
		return r;
	endfunction

	// Build one result; the offset saturates at the port width.
	function automatic res_t mk(input kind_t k, input logic [7:0] c, input logic qu,
			input logic d, input logic [POSITION_BITS-1:0] off);
		res_t r;
		r.kind   = k;
		r.tbyte  = c;
		r.quoted = qu;
		r.disc   = d;
		r.offs   = ((off >> OFFSET_W) != '0) ? '1 : OFFSET_W'(off);
		r.last   = 1'b0;
		return r;
	endfunction

	// Input register.
	logic                     valid_s1;
	logic [7:0]               byte_s1;

	// Scanner state.
	mode_t                    mode_q, mode_d;
	logic [LEN_W-1:0]         len_q, len_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [POSITION_BITS-1:0] begin_q, begin_d;

	// Result queue.
	res_t                     q_mem_q [QDEPTH];
	logic [PTR_W-1:0]         wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]         count_q;

	res_t                     res [3];
	logic [1:0]               n;
	logic                     printable;
	logic                     pop;
	logic                     advance;
	logic [CNT_W:0]           count_next;

	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);

	// Queue fill after this cycle's pop and push; the decoded byte is only
	// consumed when all of its results fit.
	assign count_next = {1'b0, count_q} - (CNT_W+1)'(pop) + (CNT_W+1)'(n);
	assign advance    = valid_s1 && (count_next <= (CNT_W+1)'(QDEPTH));
	assign in_stall   = valid_s1 && !advance;

	// Decode of the registered byte against the scanner mode.
	always_comb begin
		res[0]    = '0;
		res[1]    = '0;
		res[2]    = '0;
		n         = 2'd0;
		mode_d    = mode_q;
		len_d     = len_q;
		begin_d   = begin_q;
		printable = (byte_s1 > CH_SPACE) && !byte_s1[7];
		pos_d     = (byte_s1 == CH_NUL) ? '0 : sat_inc(pos_q);

		unique case (mode_q)
			MODE_SLASH: begin
				if (byte_s1 == CH_SLASH) begin
					mode_d = MODE_COMMENT;
				end else begin
					// A lone slash opens a bare word; it is emitted now.
					res[0] = mk(KIND_BYTE, CH_SLASH, 1'b0, 1'b0, begin_q);
					if (printable) begin
						mode_d = MODE_WORD;
						if (LEN_ONE < LEN_MAX) begin
							res[1] = mk(KIND_BYTE, byte_s1, 1'b0, 1'b0, begin_q);
							n      = 2'd2;
							len_d  = LEN_ONE + LEN_ONE;
						end else begin
							n      = 2'd1;
							len_d  = LEN_ONE;
						end
					end else begin
						mode_d = MODE_SKIP;
						len_d  = LEN_ONE;
						res[1] = mk(KIND_END, CH_NUL, 1'b0, LEN_ONE == LEN_MAX, begin_q);
						n      = 2'd2;
						if (byte_s1 == CH_NUL) begin
							res[2] = mk(KIND_EOT, CH_NUL, 1'b0, 1'b0, '0);
							n      = 2'd3;
						end
					end
				end
			end
			MODE_COMMENT: begin
				if (byte_s1 == CH_NUL) begin
					res[0] = mk(KIND_EOT, CH_NUL, 1'b0, 1'b0, '0);
					n      = 2'd1;
					mode_d = MODE_SKIP;
				end else if (byte_s1 == CH_NL) begin
					mode_d = MODE_SKIP;
				end
			end
			MODE_QUOTED: begin
				if (byte_s1 == CH_QUOTE || byte_s1 == CH_NUL) begin
					res[0] = mk(KIND_END, CH_NUL, 1'b1, 1'b0, begin_q);
					n      = 2'd1;
					mode_d = MODE_SKIP;
					if (byte_s1 == CH_NUL) begin
						res[1] = mk(KIND_EOT, CH_NUL, 1'b0, 1'b0, '0);
						n      = 2'd2;
					end
				end else if (len_q < LEN_QMAX) begin
					// Quoted strings keep one slot free; further bytes are dropped, yet their discarded flag stays clear.
					res[0] = mk(KIND_BYTE, byte_s1, 1'b1, 1'b0, begin_q);
					n      = 2'd1;
					len_d  = len_q + LEN_ONE;
				end
			end
			MODE_WORD: begin
				if (printable) begin
					if (len_q < LEN_MAX) begin
						res[0] = mk(KIND_BYTE, byte_s1, 1'b0, 1'b0, begin_q);
						n      = 2'd1;
						len_d  = len_q + LEN_ONE;
					end
				end else begin
					res[0] = mk(KIND_END, CH_NUL, 1'b0, len_q == LEN_MAX, begin_q);
					n      = 2'd1;
					mode_d = MODE_SKIP;
					if (byte_s1 == CH_NUL) begin
						res[1] = mk(KIND_EOT, CH_NUL, 1'b0, 1'b0, '0);
						n      = 2'd2;
					end
				end
			end
			default: begin
				// Skipping whitespace; also the recovery path for a corrupted mode.
				mode_d = MODE_SKIP;
				if (byte_s1 == CH_NUL) begin
					res[0] = mk(KIND_EOT, CH_NUL, 1'b0, 1'b0, '0);
					n      = 2'd1;
				end else if (!printable) begin
					mode_d = MODE_SKIP;
				end else if (byte_s1 == CH_SLASH) begin
					mode_d  = MODE_SLASH;
					begin_d = pos_q;
				end else if (byte_s1 == CH_QUOTE) begin
					// The token starts after the opening quote.
					mode_d  = MODE_QUOTED;
					begin_d = sat_inc(pos_q);
					len_d   = '0;
				end else begin
					mode_d  = MODE_WORD;
					begin_d = pos_q;
					len_d   = LEN_ONE;
					res[0]  = mk(KIND_BYTE, byte_s1, 1'b0, 1'b0, pos_q);
					n       = 2'd1;
				end
			end
		endcase

		for (int i = 0; i < 3; i++) begin
			res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
		end
	end

	// Input register: reloads whenever the held byte is consumed or absent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
		end
	end

	// Scanner state and queue control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SKIP;
			len_q    <= '0;
			pos_q    <= '0;
			begin_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				mode_q   <= mode_d;
				len_q    <= len_d;
				pos_q    <= pos_d;
				begin_q  <= begin_d;
				wr_ptr_q <= wr_ptr_q + PTR_W'(n);
				count_q  <= CNT_W'(count_next);
			end else begin
				count_q  <= count_q - CNT_W'(pop);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
		end
	end

	// Result payload storage.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (advance && (2'(i) < n)) begin
				q_mem_q[wr_ptr_q + PTR_W'(i)] <= res[i];
			end
		end
	end

	assign kind         = q_mem_q[rd_ptr_q].kind;
	assign token_byte   = q_mem_q[rd_ptr_q].tbyte;
	assign quoted       = q_mem_q[rd_ptr_q].quoted;
	assign discarded    = q_mem_q[rd_ptr_q].disc;
	assign start_offset = q_mem_q[rd_ptr_q].offs;
	assign last         = q_mem_q[rd_ptr_q].last;

`ifndef ASSERT_OFF
	// The queue never holds more results than it has entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("result queue overfilled");

	// Backpressure only ever comes from a held byte.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// A consumed end-of-text byte always closes with an end-of-text result.
	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_s1 == CH_NUL) |->
			(n != 2'd0) && ((n == 2'd1 && res[0].kind == KIND_EOT) ||
			(n == 2'd2 && res[1].kind == KIND_EOT) ||
			(n == 2'd3 && res[2].kind == KIND_EOT)))
		else $error("end of text not reported");

	// After end of text the scanner is back to skipping at offset zero.
	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_s1 == CH_NUL) |=> (mode_q == MODE_SKIP) && (pos_q == '0))
		else $error("scanner not rewound after end of text");

	// Fill level tracks pushes and pops exactly.
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> ({1'b0, count_q} == $past(count_next)))
		else $error("queue count out of step");
`endif

endmodule

>>> test/tokenizer_checker.sv
`timescale 1ns / 100ps
// Checker for the text tokenizer: predicts token results per accepted byte and compares them.
module tokenizer_checker
	import ttcq_pkg::*;
#(
	parameter int unsigned MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
	parameter int unsigned POSITION_BITS = DEF_POSITION_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [7:0]          text_byte,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [1:0]          kind,
	input  logic [7:0]          token_byte,
	input  logic                quoted,
	input  logic                discarded,
	input  logic [OFFSET_W-1:0] start_offset,
	input  logic                last,
	output int                  failures,
	output int                  pending
);

	localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS) - 1;
	localparam logic [7:0] FIRST_HIGH = 8'h80;

	mode_t             scan_state;
	int unsigned       chars_in_token;
	longint unsigned   next_offset;
	longint unsigned   token_start;
	res_t              token_results_due[$];
	res_t              step_results[3];
	int                step_count;

	initial begin
		failures = 0;
		pending = 0;
	end

	function automatic logic [OFFSET_W-1:0] clip_offset(longint unsigned v);
		return (v > 65535) ? '1 : OFFSET_W'(v);
	endfunction

	function automatic longint unsigned bump(longint unsigned v);
		return (v >= POS_LIMIT) ? POS_LIMIT : v + 1;
	endfunction

	function void stage(kind_t k, logic [7:0] c, logic q, logic d, longint unsigned o);
		step_results[step_count] = '{kind: k, tbyte: c, quoted: q, disc: d,
			offs: clip_offset(o), last: 1'b0};
		step_count++;
	endfunction

	function void word_char_out(logic [7:0] c);
		if (chars_in_token < MAX_TOKEN_LEN) begin
			chars_in_token++;
			stage(KIND_BYTE, c, 1'b0, 1'b0, token_start);
		end
	endfunction

	function void word_continue(logic [7:0] c);
		if (c > CH_SPACE && c < FIRST_HIGH) begin
			word_char_out(c);
		end else begin
			stage(KIND_END, CH_NUL, 1'b0, chars_in_token == MAX_TOKEN_LEN, token_start);
			if (c == CH_NUL)
				stage(KIND_EOT, CH_NUL, 1'b0, 1'b0, 0);
			scan_state = MODE_SKIP;
		end
	endfunction

	function void tokenize_byte(logic [7:0] c);
		longint unsigned here;
		here = next_offset;
		step_count = 0;
		case (scan_state)
			MODE_SLASH: begin
				if (c == CH_SLASH) begin
					scan_state = MODE_COMMENT;
				end else begin
					scan_state = MODE_WORD;
					chars_in_token = 0;
					word_char_out(CH_SLASH);
					word_continue(c);
				end
			end
			MODE_COMMENT: begin
				if (c == CH_NUL) begin
					stage(KIND_EOT, CH_NUL, 1'b0, 1'b0, 0);
					scan_state = MODE_SKIP;
				end else if (c == CH_NL) begin
					scan_state = MODE_SKIP;
				end
			end
			MODE_QUOTED: begin
				if (c == CH_QUOTE || c == CH_NUL) begin
					stage(KIND_END, CH_NUL, 1'b1, 1'b0, token_start);
					if (c == CH_NUL)
						stage(KIND_EOT, CH_NUL, 1'b0, 1'b0, 0);
					scan_state = MODE_SKIP;
				end else if (chars_in_token + 1 < MAX_TOKEN_LEN) begin
					chars_in_token++;
					stage(KIND_BYTE, c, 1'b1, 1'b0, token_start);
				end
			end
			MODE_WORD: begin
				word_continue(c);
			end
			default: begin
				scan_state = MODE_SKIP;
				if (c == CH_NUL) begin
					stage(KIND_EOT, CH_NUL, 1'b0, 1'b0, 0);
				end else if (c <= CH_SPACE || c >= FIRST_HIGH) begin
					// Delimiters and high bytes between tokens are dropped.
				end else if (c == CH_SLASH) begin
					scan_state = MODE_SLASH;
					token_start = here;
				end else if (c == CH_QUOTE) begin
					scan_state = MODE_QUOTED;
					token_start = bump(here);
					chars_in_token = 0;
				end else begin
					scan_state = MODE_WORD;
					token_start = here;
					chars_in_token = 0;
					word_char_out(c);
				end
			end
		endcase
		next_offset = (c == CH_NUL) ? 0 : bump(here);
		if (step_count > 0)
			step_results[step_count - 1].last = 1'b1;
		for (int i = 0; i < step_count; i++)
			token_results_due.push_back(step_results[i]);
	endfunction

	task report(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		failures++;
	endtask

	task check_result();
		res_t want;
		if (token_results_due.size() == 0) begin
			report($sformatf("result with nothing expected: kind %0d byte %02h", kind, token_byte));
		end else begin
			want = token_results_due.pop_front();
			if (kind !== want.kind)
				report($sformatf("kind %0d, expected %0d", kind, want.kind));
			if (token_byte !== want.tbyte)
				report($sformatf("token_byte %02h, expected %02h", token_byte, want.tbyte));
			if (quoted !== want.quoted)
				report($sformatf("quoted %b, expected %b", quoted, want.quoted));
			if (discarded !== want.disc)
				report($sformatf("discarded %b, expected %b", discarded, want.disc));
			if (start_offset !== want.offs)
				report($sformatf("start_offset %0d, expected %0d", start_offset, want.offs));
			if (last !== want.last)
				report($sformatf("last %b, expected %b", last, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_state = MODE_SKIP;
			chars_in_token = 0;
			next_offset = 0;
			token_start = 0;
			token_results_due.delete();
		end else begin
			if (in_valid && !in_stall)
				tokenize_byte(text_byte);
			if (out_valid && !out_stall)
				check_result();
		end
		pending = token_results_due.size();
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for the text tokenizer: stimulus, stall patterns and the verdict.
module tb_top;
	import ttcq_pkg::*;

	// The whole run stays far below this; hitting it means the block hung.
	localparam int CYCLE_LIMIT   = 1000000;
	// Slack after the final drain before the verdict is taken.
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS  = 450;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          text_byte;
	logic                out_valid;
	logic                out_stall;
	logic [1:0]          kind;
	logic [7:0]          token_byte;
	logic                quoted;
	logic                discarded;
	logic [OFFSET_W-1:0] start_offset;
	logic                last;
	int                  failures;
	int                  pending;

	int                  cycles = 0;
	int                  bytes_sent = 0;
	int                  burst_left = 0;
	bit                  gaps_on = 1'b1;
	int                  stall_style = 0;
	int                  style_left = 0;
	logic [7:0]          text_bytes[$];

	text_tokenizer_comments_quotes DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.token_byte   (token_byte),
		.quoted       (quoted),
		.discarded    (discarded),
		.start_offset (start_offset),
		.last         (last)
	);

	tokenizer_checker CHK (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.token_byte   (token_byte),
		.quoted       (quoted),
		.discarded    (discarded),
		.start_offset (start_offset),
		.last         (last),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog. A correct run never gets near the limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("text_tokenizer_comments_quotes test failed");
			$finish;
		end
	end

	// The receiver picks a stall style for a random stretch of cycles: no stalls at
	// all, light random stalls, heavy random stalls, or a fixed periodic pattern.
	always @(negedge clk) begin
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 3);
			style_left = $urandom_range(20, 120);
		end
		style_left--;
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((cycles % 5) < 2);
		endcase
	end

	// Offers one beat at a falling edge and returns at the falling edge after the
	// rising edge that took it. While gaps are on, the sender works in bursts and
	// drops valid for a random number of cycles between them.
	task automatic send_byte(logic [7:0] b);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_text();
		foreach (text_bytes[i])
			send_byte(text_bytes[i]);
	endtask

	// Holds the input off until every predicted result has come out. The loop runs
	// at least once so that valid is never lowered and raised in the same step.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// A run of one to three delimiter bytes: space, newline, tab, any other control
	// byte, or a byte with the top bit set.
	task automatic push_delims();
		int n;
		n = $urandom_range(1, 3);
		repeat (n) begin
			case ($urandom_range(0, 4))
				0: text_bytes.push_back(CH_SPACE);
				1: text_bytes.push_back(CH_NL);
				2: text_bytes.push_back(8'h09);
				3: text_bytes.push_back(8'($urandom_range(1, 32)));
				default: text_bytes.push_back(8'($urandom_range(128, 255)));
			endcase
		end
	endtask

	// Token lengths are mostly short; now and then one comes near or runs past the length cap.
	function automatic int pick_len(int lo);
		if ($urandom_range(0, 29) == 0)
			return $urandom_range(120, 135);
		return $urandom_range(lo, 8);
	endfunction

	// A bare word. Its first character is neither a slash nor a quote so that it
	// really opens a word; the rest may be any printable byte.
	task automatic push_word(int len);
		logic [7:0] c;
		do c = 8'($urandom_range(33, 127)); while (c == CH_SLASH || c == CH_QUOTE);
		text_bytes.push_back(c);
		for (int i = 1; i < len; i++)
			text_bytes.push_back(8'($urandom_range(33, 127)));
	endtask

	task automatic push_quoted(int len, bit closed);
		logic [7:0] c;
		text_bytes.push_back(CH_QUOTE);
		repeat (len) begin
			do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
			text_bytes.push_back(c);
		end
		if (closed)
			text_bytes.push_back(CH_QUOTE);
	endtask

	task automatic push_comment(int len, bit closed);
		logic [7:0] c;
		text_bytes.push_back(CH_SLASH);
		text_bytes.push_back(CH_SLASH);
		repeat (len) begin
			do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
			text_bytes.push_back(c);
		end
		if (closed)
			text_bytes.push_back(CH_NL);
	endtask

	// Builds one text ending in a zero byte. Most texts are a sequence of proper
	// tokens split by delimiters; the last token may be cut off by the end of text.
	// About one text in ten is plain noise.
	task automatic build_text();
		int pieces;
		bit tail;
		text_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 30))
				text_bytes.push_back(8'($urandom_range(1, 255)));
		end else begin
			pieces = $urandom_range(1, 6);
			for (int p = 0; p < pieces; p++) begin
				tail = (p == pieces - 1);
				if (p > 0 || $urandom_range(0, 1))
					push_delims();
				case ($urandom_range(0, 9))
					0, 1, 2, 3: push_word(pick_len(1));
					4, 5: push_quoted(pick_len(0), !(tail && $urandom_range(0, 2) == 0));
					6: push_comment($urandom_range(0, 6), !(tail && $urandom_range(0, 1)));
					7: begin
						// A slash that does not open a comment becomes a word.
						text_bytes.push_back(CH_SLASH);
						if ($urandom_range(0, 1))
							push_word($urandom_range(1, 3));
					end
					default: push_delims();
				endcase
			end
			if ($urandom_range(0, 1))
				push_delims();
		end
		text_bytes.push_back(CH_NUL);
	endtask

	initial begin
		in_valid = 1'b0;
		text_byte = 8'h00;
		out_stall = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening: the lowest and highest word characters, skipped high
		// bytes, an empty quoted string, a lone slash before a space, a comment up to
		// a newline, a quote cut off by the end of text, a lone slash right before
		// the end of text (three results from one byte), a word ended by the end of
		// text, a comment cut off by the end of text, and an empty text.
		text_bytes = '{8'h21, 8'h7F, CH_SPACE, 8'hFF, 8'h80, CH_QUOTE, CH_QUOTE,
			CH_SLASH, CH_SPACE, CH_SLASH, CH_SLASH, 8'hFF, CH_NL,
			CH_QUOTE, 8'h41, CH_NUL,
			CH_SLASH, CH_NUL,
			8'h41, CH_NUL,
			CH_SLASH, CH_SLASH, 8'h41, CH_NUL,
			CH_NUL};
		send_text();
		// Let everything drain once before the random part starts.
		drain_results();

		bytes_sent = 0;
		while (bytes_sent < RANDOM_ITEMS) begin
			gaps_on = ($urandom_range(0, 4) != 0);
			build_text();
			send_text();
			if ($urandom_range(0, 7) == 0)
				drain_results();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("text_tokenizer_comments_quotes test passed");
		else
			$display("text_tokenizer_comments_quotes test failed");
		$finish;
	end

endmodule
